FILE: design/lcqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcqm_pkg
// opcodes, status codes and sizes of the lock and condition queue manager
// ----------------------------------------------------------------------------
package lcqm_pkg;

  localparam int NUM_THREADS = 16;
  localparam int NUM_LOCKS   = 16;
  localparam int NUM_CONDS   = 4;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_YIELD     = 3'd1,
    OP_LOCK      = 3'd2,
    OP_UNLOCK    = 3'd3,
    OP_WAIT      = 3'd4,
    OP_SIGNAL    = 3'd5,
    OP_BROADCAST = 3'd6,
    OP_DISPATCH  = 3'd7
  } op_e;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BLOCKED     = 3'd1;
  localparam logic [2:0] ST_NOT_STARTED = 3'd2;
  localparam logic [2:0] ST_ALREADY     = 3'd3;
  localparam logic [2:0] ST_NOT_HOLDER  = 3'd4;
  localparam logic [2:0] ST_READY_EMPTY = 3'd5;

endpackage

FILE: design/lock_and_condition_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_and_condition_queue_manager
// thread ready queue, lock owners, lock wait queues and condition queues
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (op, thread, lock, condition) and each
// gives exactly one response on the out channel (status, thread_out and its
// valid bit). started_wr_i/started_i write the started register; the user
// is to write it only while idle, which the block itself does not enforce.
// At accept the lock queue, condition queue and link memories are
// addressed (registered read); in S_READ the read words are used, the
// memories are updated and the response is registered. A second dependent
// link read (pop after a pop) goes through S_LINK when unlock, wait or
// signal hands over a waiter; wait with a lock waiter then appends the
// caller to the condition queue in S_DONE. Dispatch reads the link of the
// ready head at accept.
// The lock and condition queue memories use one address for read and
// write, the link memory has separate ones; the sequencer serializes their accesses.
// Lock owners and the ready queue pointers live in flip-flops, with one
// valid bit per lock queue and condition queue entry cleared by reset, so
// the block is usable immediately after reset. A stalled receiver holds
// the response; a new request is accepted once the response is taken.
// ----------------------------------------------------------------------------
module lock_and_condition_queue_manager
  import lcqm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       started_wr_i,
  input  logic       started_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [3:0] thread_id_i,
  input  logic [3:0] lock_id_i,
  input  logic [1:0] cond_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [3:0] thread_out_o,
  output logic       thread_out_valid_o
);

  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int CW = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
  localparam int NQ = NUM_LOCKS * NUM_CONDS;
  localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LINK, S_DONE} state_e;

  state_e state_q;
  logic started_q;
  op_e op_q;
  logic [TW-1:0] tid_q;
  logic [LW-1:0] lk_q;
  logic [QW-1:0] cq_q;

  logic [TW-1:0] rhead_q, rtail_q;
  logic rne_q;
  logic [NUM_LOCKS-1:0] own_v_q;
  logic [TW-1:0] own_t_q [NUM_LOCKS];
  logic [NUM_LOCKS-1:0] lq_ne_q;
  logic [NQ-1:0] cq_ne_q;

  // rams
  logic link_we; logic [TW-1:0] link_wa, link_ra, link_rd, link_wd;
  logic lq_we; logic [LW-1:0] lq_a; logic [2*TW-1:0] lq_wd, lq_rd;
  logic cqm_we; logic [QW-1:0] cqm_a; logic [2*TW-1:0] cqm_wd, cqm_rd;

  lcqm_ram #(.Width(TW), .Depth(NUM_THREADS)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd));
  lcqm_ram #(.Width(2*TW), .Depth(NUM_LOCKS)) u_lq (
    .clk_i, .we_i(lq_we), .waddr_i(lq_a), .wdata_i(lq_wd),
    .raddr_i(lq_a), .rdata_o(lq_rd));
  lcqm_ram #(.Width(2*TW), .Depth(NQ)) u_cq (
    .clk_i, .we_i(cqm_we), .waddr_i(cqm_a), .wdata_i(cqm_wd),
    .raddr_i(cqm_a), .rdata_o(cqm_rd));

  logic [TW-1:0] in_tid;
  logic [LW-1:0] in_lk;
  logic [CW-1:0] in_cd;
  assign in_tid = TW'(32'(thread_id_i) % NUM_THREADS);
  assign in_lk  = LW'(32'(lock_id_i) % NUM_LOCKS);
  assign in_cd  = CW'(32'(cond_id_i) % NUM_CONDS);

  logic [TW-1:0] lqh, lqt, cqh, cqt;
  assign lqh = lq_rd[2*TW-1:TW];
  assign lqt = lq_rd[TW-1:0];
  assign cqh = cqm_rd[2*TW-1:TW];
  assign cqt = cqm_rd[TW-1:0];

  // saved queue words for link state
  logic [TW-1:0] sh_q;
  logic [TW-1:0] w_q;
  logic [TW-1:0] lqt_s_q;
  logic [TW-1:0] cqt_s_q;

  logic accept;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign accept = in_valid_i && in_ready_o;

  logic own_hit, own_v;
  assign own_v   = own_v_q[lk_q];
  assign own_hit = own_v && (own_t_q[lk_q] == tid_q);

  // memory port control
  always_comb begin
    link_we = 1'b0; link_wa = rtail_q; link_wd = tid_q;
    link_ra = rhead_q;
    lq_we = 1'b0; lq_a = lk_q; lq_wd = '0;
    cqm_we = 1'b0; cqm_a = cq_q; cqm_wd = '0;
    if (accept) begin
      lq_a = in_lk;
      cqm_a = QW'(32'(in_lk) * NUM_CONDS + 32'(in_cd));
    end
    if (state_q == S_READ && started_q) begin
      case (op_q)
        OP_CREATE, OP_YIELD: begin
          link_we = rne_q;
        end
        OP_LOCK: begin
          if (own_v && !own_hit) begin
            lq_we = 1'b1;
            lq_wd = {lq_ne_q[lk_q] ? lqh : tid_q, tid_q};
            link_we = lq_ne_q[lk_q];
            link_wa = lqt;
          end
        end
        OP_UNLOCK, OP_WAIT: begin
          if (own_hit && lq_ne_q[lk_q]) link_ra = lqh;
          else if (own_hit && op_q == OP_WAIT) begin
            cqm_we = 1'b1;
            cqm_wd = {cq_ne_q[cq_q] ? cqh : tid_q, tid_q};
            link_we = cq_ne_q[cq_q];
            link_wa = cqt;
          end
        end
        OP_SIGNAL: link_ra = cqh;
        OP_BROADCAST: begin
          link_we = cq_ne_q[cq_q] && rne_q;
          link_wd = cqh;
        end
        default: link_ra = rhead_q;
      endcase
    end
    if (state_q == S_LINK) begin
      case (op_q)
        OP_UNLOCK, OP_WAIT: begin
          // pop lock queue head w_q, push it to ready
          if (w_q != lqt_s_q) begin
            lq_we = 1'b1;
            lq_wd = {link_rd, lqt_s_q};
          end
          link_we = rne_q;
          link_wa = rtail_q;
          link_wd = w_q;
        end
        OP_SIGNAL: begin
          if (w_q != lqt_s_q) begin
            cqm_we = 1'b1;
            cqm_wd = {link_rd, lqt_s_q};
          end
          link_we = rne_q;
          link_wa = rtail_q;
          link_wd = w_q;
        end
        default: ;
      endcase
    end
    if (state_q == S_DONE && op_q == OP_WAIT) begin
      cqm_we = 1'b1;
      cqm_wd = {cq_ne_q[cq_q] ? sh_q : tid_q, tid_q};
      link_we = cq_ne_q[cq_q];
      link_wa = cqt_s_q;
      link_wd = tid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      started_q <= 1'b0;
      out_valid_o <= 1'b0;
      rhead_q <= '0; rtail_q <= '0; rne_q <= 1'b0;
      own_v_q <= '0; lq_ne_q <= '0; cq_ne_q <= '0;
      op_q <= OP_CREATE; tid_q <= '0; lk_q <= '0; cq_q <= '0;
      status_o <= ST_OK; thread_out_o <= '0; thread_out_valid_o <= 1'b0;
      sh_q <= '0; w_q <= '0; lqt_s_q <= '0; cqt_s_q <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) own_t_q[i] <= '0;
    end else begin
      if (started_wr_i) started_q <= started_i;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= op_e'(op_i);
            tid_q <= in_tid; lk_q <= in_lk;
            cq_q <= QW'(32'(in_lk) * NUM_CONDS + 32'(in_cd));
            state_q <= S_READ;
          end
        end
        S_READ: begin
          status_o <= ST_OK; thread_out_o <= '0; thread_out_valid_o <= 1'b0;
          state_q <= S_IDLE;
          out_valid_o <= 1'b1;
          if (!started_q) status_o <= ST_NOT_STARTED;
          else begin
            case (op_q)
              OP_CREATE, OP_YIELD: begin
                if (!rne_q) rhead_q <= tid_q;
                rtail_q <= tid_q; rne_q <= 1'b1;
              end
              OP_LOCK: begin
                if (own_hit) status_o <= ST_ALREADY;
                else if (!own_v) begin
                  own_v_q[lk_q] <= 1'b1; own_t_q[lk_q] <= tid_q;
                end else begin
                  lq_ne_q[lk_q] <= 1'b1; status_o <= ST_BLOCKED;
                end
              end
              OP_UNLOCK, OP_WAIT: begin
                if (!own_hit) status_o <= ST_NOT_HOLDER;
                else if (lq_ne_q[lk_q]) begin
                  w_q <= lqh; lqt_s_q <= lqt;
                  sh_q <= cqh; cqt_s_q <= cqt;
                  out_valid_o <= 1'b0; state_q <= S_LINK;
                end else begin
                  own_v_q[lk_q] <= 1'b0;
                  if (op_q == OP_WAIT) begin
                    cq_ne_q[cq_q] <= 1'b1; status_o <= ST_BLOCKED;
                  end
                end
              end
              OP_SIGNAL: begin
                if (cq_ne_q[cq_q]) begin
                  w_q <= cqh; lqt_s_q <= cqt;
                  out_valid_o <= 1'b0; state_q <= S_LINK;
                end
              end
              OP_BROADCAST: begin
                if (cq_ne_q[cq_q]) begin
                  if (!rne_q) rhead_q <= cqh;
                  rtail_q <= cqt; rne_q <= 1'b1;
                  cq_ne_q[cq_q] <= 1'b0;
                end
              end
              default: begin
                if (!rne_q) status_o <= ST_READY_EMPTY;
                else begin
                  thread_out_o <= 4'(rhead_q); thread_out_valid_o <= 1'b1;
                  if (rhead_q == rtail_q) rne_q <= 1'b0;
                  else rhead_q <= link_rd;
                end
              end
            endcase
          end
        end
        S_LINK: begin
          if (!rne_q) rhead_q <= w_q;
          rtail_q <= w_q; rne_q <= 1'b1;
          if (op_q == OP_SIGNAL) begin
            if (w_q == lqt_s_q) cq_ne_q[cq_q] <= 1'b0;
            out_valid_o <= 1'b1; state_q <= S_IDLE;
          end else begin
            if (w_q == lqt_s_q) lq_ne_q[lk_q] <= 1'b0;
            own_t_q[lk_q] <= w_q;
            thread_out_o <= 4'(w_q); thread_out_valid_o <= 1'b1;
            if (op_q == OP_WAIT) begin
              status_o <= ST_BLOCKED; state_q <= S_DONE;
            end else begin
              out_valid_o <= 1'b1; state_q <= S_IDLE;
            end
          end
        end
        default: begin
          cq_ne_q[cq_q] <= 1'b1;
          out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/lcqm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcqm_ram
// synchronous ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module lcqm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: verif/lock_and_condition_queue_manager_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_and_condition_queue_manager_checker
// watches both channels, predicts every response and compares it
// ----------------------------------------------------------------------------
// Keeps its own copy of the ready queue, the lock owners, the lock wait
// queues, the condition queues and the shared link array. Each accepted
// request is run through the prediction; each accepted response is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lock_and_condition_queue_manager_checker
  import lcqm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       started_wr_i,
  input  logic       started_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] op_i,
  input  logic [3:0] thread_id_i,
  input  logic [3:0] lock_id_i,
  input  logic [1:0] cond_id_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] status_i,
  input  logic [3:0] thread_out_i,
  input  logic       thread_out_valid_i,
  output int         pending_o,
  output int         fail_count_o
);

  typedef struct packed {
    logic [3:0] head;
    logic [3:0] tail;
    logic       nonempty;
  } thread_list_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] thread;
    logic       thread_valid;
  } outcome_t;

  logic         started_q;
  logic [3:0]   link_q [16];
  thread_list_t ready_list;
  logic         owner_valid [16];
  logic [3:0]   owner_tid [16];
  thread_list_t lock_wait [16];
  thread_list_t cond_wait [64];
  outcome_t     expected_outcomes [$];

  function automatic void list_push(inout thread_list_t q, input logic [3:0] t);
    if (q.nonempty) link_q[q.tail] = t;
    else q.head = t;
    q.tail = t;
    q.nonempty = 1'b1;
  endfunction

  function automatic logic [3:0] list_pop(inout thread_list_t q);
    logic [3:0] h;
    h = q.head;
    if (h == q.tail) q.nonempty = 1'b0;
    else q.head = link_q[h];
    return h;
  endfunction

  function automatic outcome_t predict_outcome(input op_e op, input logic [3:0] t,
                                               input logic [3:0] l, input logic [1:0] c);
    outcome_t   r;
    logic [5:0] ci;
    logic [3:0] w;
    r = '0;
    ci = {l, c};
    if (!started_q) begin
      r.status = ST_NOT_STARTED;
    end else begin
      case (op)
        OP_CREATE, OP_YIELD: list_push(ready_list, t);
        OP_LOCK: begin
          if (owner_valid[l] && owner_tid[l] == t) begin
            r.status = ST_ALREADY;
          end else if (!owner_valid[l]) begin
            owner_valid[l] = 1'b1;
            owner_tid[l] = t;
          end else begin
            list_push(lock_wait[l], t);
            r.status = ST_BLOCKED;
          end
        end
        OP_UNLOCK, OP_WAIT: begin
          if (!owner_valid[l] || owner_tid[l] != t) begin
            r.status = ST_NOT_HOLDER;
          end else begin
            owner_valid[l] = 1'b0;
            if (lock_wait[l].nonempty) begin
              w = list_pop(lock_wait[l]);
              list_push(ready_list, w);
              owner_valid[l] = 1'b1;
              owner_tid[l] = w;
              r.thread = w;
              r.thread_valid = 1'b1;
            end
            if (op == OP_WAIT) begin
              list_push(cond_wait[ci], t);
              r.status = ST_BLOCKED;
            end
          end
        end
        OP_SIGNAL: begin
          if (cond_wait[ci].nonempty) begin
            w = list_pop(cond_wait[ci]);
            list_push(ready_list, w);
          end
        end
        OP_BROADCAST: begin
          if (cond_wait[ci].nonempty) begin
            if (ready_list.nonempty) link_q[ready_list.tail] = cond_wait[ci].head;
            else ready_list.head = cond_wait[ci].head;
            ready_list.tail = cond_wait[ci].tail;
            ready_list.nonempty = 1'b1;
            cond_wait[ci].nonempty = 1'b0;
          end
        end
        default: begin
          if (!ready_list.nonempty) begin
            r.status = ST_READY_EMPTY;
          end else begin
            r.thread = list_pop(ready_list);
            r.thread_valid = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    int       d;
    if (!rst_ni) begin
      started_q = 1'b0;
      ready_list = '0;
      for (int i = 0; i < 16; i++) begin
        link_q[i] = '0;
        owner_valid[i] = 1'b0;
        owner_tid[i] = '0;
        lock_wait[i] = '0;
      end
      for (int i = 0; i < 64; i++) cond_wait[i] = '0;
      expected_outcomes.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      d = 0;
      if (in_valid_i && in_ready_i) begin
        expected_outcomes.push_back(predict_outcome(op_e'(op_i), thread_id_i,
                                                    lock_id_i, cond_id_i));
        d++;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected response status=%0d thread=%0d valid=%0d",
                   $time, status_i, thread_out_i, thread_out_valid_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_outcomes.pop_front();
          d--;
          if (e.status !== status_i || e.thread !== thread_out_i ||
              e.thread_valid !== thread_out_valid_i) begin
            $display("%0t: mismatch expected status=%0d thread=%0d valid=%0d, got %0d %0d %0d",
                     $time, e.status, e.thread, e.thread_valid,
                     status_i, thread_out_i, thread_out_valid_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= pending_o + d;
      if (started_wr_i) started_q = started_i;
    end
  end

endmodule

FILE: verif/lock_and_condition_queue_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_and_condition_queue_manager_tb
// regression of the lock and condition queue manager
// ----------------------------------------------------------------------------
// Drives directed and random requests with random gaps and response stalls,
// toggles the started register between phases, and lets the checker judge
// every response.
// ----------------------------------------------------------------------------
module lock_and_condition_queue_manager_tb;
  import lcqm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       started_wr;
  logic       started;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] op;
  logic [3:0] thread_id;
  logic [3:0] lock_id;
  logic [1:0] cond_id;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [3:0] thread_out;
  logic       thread_out_valid;
  int         pending;
  int         fail_count;
  int         cycles;
  bit         busy_gaps;
  int         stall_left;

  lock_and_condition_queue_manager u_dut (
    .clk_i(clk), .rst_ni(rst_n), .started_wr_i(started_wr), .started_i(started),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .op_i(op), .thread_id_i(thread_id),
    .lock_id_i(lock_id), .cond_id_i(cond_id), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .status_o(status), .thread_out_o(thread_out),
    .thread_out_valid_o(thread_out_valid)
  );

  lock_and_condition_queue_manager_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .started_wr_i(started_wr), .started_i(started),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .op_i(op), .thread_id_i(thread_id),
    .lock_id_i(lock_id), .cond_id_i(cond_id), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .status_i(status), .thread_out_i(thread_out),
    .thread_out_valid_i(thread_out_valid), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lock_and_condition_queue_manager regression: fail");
      $finish;
    end
  end

  // response stalls: mostly short, a few long, no new ones while gaps are off
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (busy_gaps && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                 : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input op_e o, input logic [3:0] t, input logic [3:0] l,
                              input logic [1:0] c);
    int gap;
    gap = 0;
    if (busy_gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    thread_id <= t;
    lock_id <= l;
    cond_id <= c;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_started(input logic v);
    drain();
    started_wr <= 1'b1;
    started <= v;
    @(posedge clk);
    started_wr <= 1'b0;
  endtask

  task automatic random_requests(input int n);
    op_e        o;
    logic [3:0] t;
    logic [3:0] l;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) busy_gaps = ($urandom_range(0, 3) != 0);
      o = op_e'($urandom_range(0, 7));
      // small thread and lock pools make holders, waiters and sleepers meet
      if ($urandom_range(0, 4) == 0) begin
        t = 4'($urandom_range(0, 15));
        l = 4'($urandom_range(0, 15));
      end else begin
        t = 4'($urandom_range(0, 3));
        l = 4'($urandom_range(0, 1));
      end
      send_request(o, t, l, 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    cycles = 0;
    stall_left = 0;
    busy_gaps = 1'b1;
    rst_n = 1'b0;
    started_wr = 1'b0;
    started = 1'b0;
    in_valid = 1'b0;
    op = OP_CREATE;
    thread_id = '0;
    lock_id = '0;
    cond_id = '0;
    out_ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not started yet
    send_request(OP_CREATE, 4'd15, 4'd15, 2'd3);
    send_request(OP_DISPATCH, 4'd0, 4'd0, 2'd0);
    write_started(1'b1);

    send_request(OP_DISPATCH, 4'd0, 4'd0, 2'd0);
    send_request(OP_CREATE, 4'd0, 4'd0, 2'd0);
    send_request(OP_YIELD, 4'd15, 4'd15, 2'd3);
    send_request(OP_LOCK, 4'd1, 4'd15, 2'd0);
    send_request(OP_LOCK, 4'd1, 4'd15, 2'd0);
    send_request(OP_LOCK, 4'd2, 4'd15, 2'd0);
    send_request(OP_LOCK, 4'd3, 4'd15, 2'd0);
    send_request(OP_UNLOCK, 4'd2, 4'd15, 2'd0);
    send_request(OP_WAIT, 4'd1, 4'd15, 2'd3);
    send_request(OP_UNLOCK, 4'd2, 4'd15, 2'd0);
    send_request(OP_LOCK, 4'd5, 4'd15, 2'd0);
    send_request(OP_WAIT, 4'd3, 4'd15, 2'd3);
    send_request(OP_SIGNAL, 4'd0, 4'd15, 2'd3);
    send_request(OP_BROADCAST, 4'd0, 4'd15, 2'd3);
    send_request(OP_UNLOCK, 4'd5, 4'd15, 2'd0);
    send_request(OP_SIGNAL, 4'd0, 4'd0, 2'd1);
    send_request(OP_BROADCAST, 4'd0, 4'd0, 2'd1);
    repeat (6) send_request(OP_DISPATCH, 4'd9, 4'd9, 2'd2);

    random_requests(500);
    write_started(1'b0);
    random_requests(20);
    write_started(1'b1);
    random_requests(530);

    drain();
    if (fail_count == 0) begin
      $display("lock_and_condition_queue_manager regression: pass");
    end else begin
      $display("lock_and_condition_queue_manager regression: fail");
    end
    $finish;
  end

endmodule
